FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/x86eu_pkg.sv
// ----------------------------------------------------------------------------
// x86eu_pkg
// Types and constants shared by the execute unit modules.
// ----------------------------------------------------------------------------
package x86eu_pkg;

	typedef enum logic [1:0] {
		REQ_EXEC  = 2'd0,
		REQ_WRMEM = 2'd1,
		REQ_RDMEM = 2'd2,
		REQ_RDREG = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		OP_MOV_IR  = 4'd0,
		OP_MOV_RM  = 4'd1,
		OP_MOV_IM  = 4'd2,
		OP_ADD     = 4'd3,
		OP_ADD_I   = 4'd4,
		OP_SUB     = 4'd5,
		OP_SUB_I   = 4'd6,
		OP_CMP     = 4'd7,
		OP_CMP_I   = 4'd8,
		OP_JNE     = 4'd9
	} op_t;

	localparam logic [1:0] MOD_REG = 2'd3;
	localparam logic [2:0] RM_BP   = 3'd6;

	localparam logic [2:0] R_BX = 3'd3;
	localparam logic [2:0] R_BP = 3'd5;
	localparam logic [2:0] R_SI = 3'd6;
	localparam logic [2:0] R_DI = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_EXEC,
		ST_WR1,
		ST_DONE
	} state_t;

	// ALU operation selector
	typedef enum logic [1:0] {
		ALU_PASS,
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic        word;
		logic [15:0] a;
		logic [15:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [15:0] res;
		logic        zero;
		logic        sign;
	} alu_rsp_t;

endpackage

FILE: hdl/x86eu_alu.sv
// ----------------------------------------------------------------------------
// x86eu_alu
// Shared adder/subtractor used for addresses and arithmetic.
// ----------------------------------------------------------------------------
module x86eu_alu (
	input  x86eu_pkg::alu_req_t req,
	output x86eu_pkg::alu_rsp_t rsp
);
	logic [15:0] sum;

	always_comb begin
		unique case (req.op)
			x86eu_pkg::ALU_ADD: sum = req.a + req.b;
			x86eu_pkg::ALU_SUB: sum = req.a - req.b;
			default:            sum = req.a;
		endcase
		rsp.res  = req.word ? sum : {8'h00, sum[7:0]};
		rsp.zero = (rsp.res == 16'h0000);
		rsp.sign = req.word ? sum[15] : sum[7];
	end
endmodule

FILE: hdl/x86eu_mem.sv
// ----------------------------------------------------------------------------
// x86eu_mem
// Byte-wide data memory, one port, registered read data.
// ----------------------------------------------------------------------------
module x86eu_mem #(
	parameter int MEM_BYTES = 65536
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(MEM_BYTES)-1:0] addr,
	input  logic [7:0]                   wdata,
	output logic [7:0]                   rdata
);
	logic [7:0] mem_q [MEM_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: hdl/x86_16bit_execute_unit.sv
// Memory writes, register reads and rejected forms go from IDLE to DONE; register-only
// instructions pass EXEC; memory reads pass RD0, RD1; memory operands pass RD0, RD1
// for words only, then EXEC, and WR1 for word writes. The strobe is registered from
// DONE; busy drops in the strobe cycle, so a request waits for the last one to end;
// the single byte port takes a state per memory byte. Results cannot be stalled.
// Reset clears registers, ip, flags and control; memory holds no reset value.
// ----------------------------------------------------------------------------
// x86_16bit_execute_unit
// Sequencer around one ALU and one byte memory executing 8086 subset requests.
// ----------------------------------------------------------------------------
module x86_16bit_execute_unit #(
	parameter int MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [3:0]  op_kind,
	input  logic        width_bit,
	input  logic        direction_bit,
	input  logic [1:0]  mode_field,
	input  logic [2:0]  reg_field,
	input  logic [2:0]  rm_field,
	input  logic [15:0] displacement,
	input  logic [15:0] immediate,
	input  logic [2:0]  instr_length,
	input  logic [15:0] access_address,
	input  logic [7:0]  access_data,
	output logic        done,
	output logic [15:0] next_ip,
	output logic        zero_flag,
	output logic        sign_flag,
	output logic [15:0] read_data,
	output logic        error
);
	localparam int AW = $clog2(MEM_BYTES);

	x86eu_pkg::state_t state_q, state_d;

	logic [15:0] regs_q [8];
	logic [15:0] ip_q;
	logic        zf_q, sf_q;

	// latched request
	logic [1:0]  req_q;
	logic [3:0]  op_q;
	logic        w_q, d_q;
	logic [1:0]  mod_q;
	logic [2:0]  reg_q, rm_q;
	logic [15:0] imm_q, ea_q, opnd_q;
	logic [2:0]  len_q;
	logic [15:0] res_q;

	logic        mem_we;
	logic [15:0] mem_a16;
	logic [7:0]  mem_wd, mem_rd;

	x86eu_pkg::alu_req_t alu_req;
	x86eu_pkg::alu_rsp_t alu_rsp;

	x86eu_alu u_alu (.req(alu_req), .rsp(alu_rsp));

	x86eu_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
		.clk(clk), .we(mem_we), .addr(mem_a16[AW-1:0]), .wdata(mem_wd), .rdata(mem_rd)
	);

	function automatic logic [15:0] rdreg(input logic [15:0] rf [8], input logic w,
		input logic [2:0] r);
		logic [15:0] v;
		v = rf[{1'b0, r[1:0]}];
		if (w) return rf[r];
		return r[2] ? {8'h00, v[15:8]} : {8'h00, v[7:0]};
	endfunction

	// effective address base, before the displacement add in the ALU
	logic [15:0] ea_base;
	always_comb begin
		unique case (rm_field)
			3'd0: ea_base = regs_q[x86eu_pkg::R_BX] + regs_q[x86eu_pkg::R_SI];
			3'd1: ea_base = regs_q[x86eu_pkg::R_BX] + regs_q[x86eu_pkg::R_DI];
			3'd2: ea_base = regs_q[x86eu_pkg::R_BP] + regs_q[x86eu_pkg::R_SI];
			3'd3: ea_base = regs_q[x86eu_pkg::R_BP] + regs_q[x86eu_pkg::R_DI];
			3'd4: ea_base = regs_q[x86eu_pkg::R_SI];
			3'd5: ea_base = regs_q[x86eu_pkg::R_DI];
			3'd6: ea_base = (mode_field == 2'd0) ? 16'h0000 : regs_q[x86eu_pkg::R_BP];
			default: ea_base = regs_q[x86eu_pkg::R_BX];
		endcase
	end

	logic is_mem, bad_op, immform, to_reg, writes;
	logic [15:0] mask, src_v, dst_v, rm_v;

	always_comb begin
		is_mem  = (mod_q != x86eu_pkg::MOD_REG);
		bad_op  = (op_kind > x86eu_pkg::OP_JNE) ||
			(op_kind == x86eu_pkg::OP_CMP_I && mode_field != x86eu_pkg::MOD_REG);
		immform = (op_q == x86eu_pkg::OP_ADD_I) || (op_q == x86eu_pkg::OP_SUB_I) ||
			(op_q == x86eu_pkg::OP_CMP_I);
		mask    = w_q ? 16'hFFFF : 16'h00FF;
		rm_v    = is_mem ? opnd_q : rdreg(regs_q, w_q, rm_q);
		to_reg  = !immform && d_q;
		dst_v   = to_reg ? rdreg(regs_q, w_q, reg_q) : rm_v;
		src_v   = immform ? (imm_q & mask) : (to_reg ? rm_v : rdreg(regs_q, w_q, reg_q));
		// does the op write its rm operand back
		writes  = 1'b0;
		unique case (op_q)
			x86eu_pkg::OP_MOV_RM: writes = !d_q;
			x86eu_pkg::OP_MOV_IM: writes = 1'b1;
			x86eu_pkg::OP_ADD, x86eu_pkg::OP_ADD_I,
			x86eu_pkg::OP_SUB, x86eu_pkg::OP_SUB_I: writes = !to_reg;
			default: writes = 1'b0;
		endcase
	end

	// ALU input selection per state
	always_comb begin
		alu_req = '{op: x86eu_pkg::ALU_PASS, word: 1'b1, a: 16'h0, b: 16'h0};
		if (state_q == x86eu_pkg::ST_IDLE) begin
			alu_req = '{op: x86eu_pkg::ALU_ADD, word: 1'b1, a: ea_base, b: displacement};
		end else if (state_q == x86eu_pkg::ST_EXEC) begin
			unique case (op_q)
				x86eu_pkg::OP_ADD, x86eu_pkg::OP_ADD_I:
					alu_req = '{op: x86eu_pkg::ALU_ADD, word: w_q, a: dst_v, b: src_v};
				x86eu_pkg::OP_SUB, x86eu_pkg::OP_SUB_I, x86eu_pkg::OP_CMP,
				x86eu_pkg::OP_CMP_I:
					alu_req = '{op: x86eu_pkg::ALU_SUB, word: w_q, a: dst_v, b: src_v};
				x86eu_pkg::OP_MOV_IR, x86eu_pkg::OP_MOV_IM:
					alu_req = '{op: x86eu_pkg::ALU_PASS, word: w_q, a: imm_q, b: 16'h0};
				x86eu_pkg::OP_MOV_RM:
					alu_req = '{op: x86eu_pkg::ALU_PASS, word: w_q,
						a: d_q ? rm_v : rdreg(regs_q, w_q, reg_q), b: 16'h0};
				default:
					alu_req = '{op: x86eu_pkg::ALU_PASS, word: 1'b1, a: 16'h0, b: 16'h0};
			endcase
		end
	end

	// next state and memory port
	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_a16 = ea_q;
		mem_wd  = res_q[7:0];
		unique case (state_q)
			x86eu_pkg::ST_IDLE: begin
				mem_a16 = access_address;
				if (start) begin
					priority case (req_type)
						x86eu_pkg::REQ_WRMEM: begin
							mem_we  = 1'b1;
							mem_wd  = access_data;
							state_d = x86eu_pkg::ST_DONE;
						end
						x86eu_pkg::REQ_RDMEM: state_d = x86eu_pkg::ST_RD0;
						x86eu_pkg::REQ_RDREG: state_d = x86eu_pkg::ST_DONE;
						default: begin
							mem_a16 = alu_rsp.res;
							if (bad_op) state_d = x86eu_pkg::ST_DONE;
							else if (mode_field != x86eu_pkg::MOD_REG) state_d = x86eu_pkg::ST_RD0;
							else state_d = x86eu_pkg::ST_EXEC;
						end
					endcase
				end
			end
			x86eu_pkg::ST_RD0: begin
				mem_a16 = ea_q + 16'd1;
				state_d = (w_q || req_q == x86eu_pkg::REQ_RDMEM) ? x86eu_pkg::ST_RD1
					: x86eu_pkg::ST_EXEC;
			end
			x86eu_pkg::ST_RD1: state_d = (req_q == x86eu_pkg::REQ_RDMEM) ?
				x86eu_pkg::ST_DONE : x86eu_pkg::ST_EXEC;
			x86eu_pkg::ST_EXEC: begin
				mem_wd  = alu_rsp.res[7:0];
				if (is_mem && writes && op_q != x86eu_pkg::OP_JNE) begin
					mem_we  = 1'b1;
					state_d = w_q ? x86eu_pkg::ST_WR1 : x86eu_pkg::ST_DONE;
				end else begin
					state_d = x86eu_pkg::ST_DONE;
				end
			end
			x86eu_pkg::ST_WR1: begin
				mem_we  = 1'b1;
				mem_a16 = ea_q + 16'd1;
				mem_wd  = res_q[15:8];
				state_d = x86eu_pkg::ST_DONE;
			end
			default: state_d = x86eu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= x86eu_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// architectural state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) regs_q[i] <= 16'h0000;
			ip_q  <= 16'h0000;
			zf_q  <= 1'b0;
			sf_q  <= 1'b0;
			done  <= 1'b0;
			error <= 1'b0;
		end else begin
			done <= (state_q == x86eu_pkg::ST_DONE);
			if (state_q == x86eu_pkg::ST_IDLE && start) begin
				error <= (req_type == x86eu_pkg::REQ_EXEC) && bad_op;
			end
			if (state_q == x86eu_pkg::ST_EXEC) begin
				if (op_q == x86eu_pkg::OP_JNE && !zf_q) begin
					ip_q <= ip_q + {13'd0, len_q} + imm_q;
				end else begin
					ip_q <= ip_q + {13'd0, len_q};
				end
				if (op_q >= x86eu_pkg::OP_ADD && op_q <= x86eu_pkg::OP_CMP_I) begin
					zf_q <= alu_rsp.zero;
					sf_q <= alu_rsp.sign;
				end
				if (op_q != x86eu_pkg::OP_JNE && op_q != x86eu_pkg::OP_CMP &&
					op_q != x86eu_pkg::OP_CMP_I) begin
					if (op_q == x86eu_pkg::OP_MOV_IR || (to_reg && op_q != x86eu_pkg::OP_MOV_IM)) begin
						if (w_q) regs_q[reg_q] <= alu_rsp.res;
						else if (reg_q[2]) regs_q[{1'b0, reg_q[1:0]}][15:8] <= alu_rsp.res[7:0];
						else regs_q[{1'b0, reg_q[1:0]}][7:0] <= alu_rsp.res[7:0];
					end else if (!is_mem) begin
						if (w_q) regs_q[rm_q] <= alu_rsp.res;
						else if (rm_q[2]) regs_q[{1'b0, rm_q[1:0]}][15:8] <= alu_rsp.res[7:0];
						else regs_q[{1'b0, rm_q[1:0]}][7:0] <= alu_rsp.res[7:0];
					end
				end
			end
		end
	end

	// request payload, no reset
	always_ff @(posedge clk) begin
		if (state_q == x86eu_pkg::ST_IDLE && start) begin
			req_q  <= req_type;
			op_q   <= op_kind;
			w_q    <= width_bit;
			d_q    <= direction_bit;
			mod_q  <= mode_field;
			reg_q  <= reg_field;
			rm_q   <= rm_field;
			imm_q  <= immediate;
			len_q  <= instr_length;
			ea_q   <= (req_type == x86eu_pkg::REQ_EXEC) ? alu_rsp.res : access_address;
			opnd_q <= 16'h0000;
			read_data <= (req_type == x86eu_pkg::REQ_RDREG) ? regs_q[reg_field] : 16'h0000;
		end
		// read data is registered, so it arrives in the cycle after its address: low byte in RD0, high byte in RD1
		if (state_q == x86eu_pkg::ST_RD0) opnd_q[7:0] <= mem_rd;
		if (state_q == x86eu_pkg::ST_RD1) begin
			opnd_q[15:8] <= mem_rd;
			if (req_q == x86eu_pkg::REQ_RDMEM) read_data <= {mem_rd, opnd_q[7:0]};
		end
		if (state_q == x86eu_pkg::ST_EXEC) res_q <= alu_rsp.res;
	end

	assign busy      = (state_q != x86eu_pkg::ST_IDLE);
	assign next_ip   = ip_q;
	assign zero_flag = zf_q;
	assign sign_flag = sf_q;
endmodule

FILE: hdl/x86eu_checker.sv
// ----------------------------------------------------------------------------
// x86eu_checker
// Port-level checks for the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module x86eu_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic error,
	input logic [15:0] read_data
);
	`CHK_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "busy not raised after request")
	`CHK_NEXT(a_done_single, clk, arst_n, done, !done, "strobe longer than one cycle")
	`CHK_IMPLY(a_err_rd, clk, arst_n, done && error, read_data == 16'h0000, "error with read data")
endmodule

bind x86_16bit_execute_unit x86eu_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.error(error), .read_data(read_data)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 8086 subset execute unit. Requests go in
// through the start/busy handshake, a predictor inside a scoreboard class
// tracks registers, ip, flags and memory, and each done strobe is compared
// with the oldest predicted outcome. Directed cases come first, then random
// requests. Memory is always written before it is read.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_REQS = 1200;

	typedef struct {
		x86eu_pkg::req_t rq;
		logic [3:0]  kind;
		logic        w;
		logic        d;
		logic [1:0]  mode;
		logic [2:0]  rg;
		logic [2:0]  rm;
		logic [15:0] disp;
		logic [15:0] imm;
		logic [2:0]  len;
		logic [15:0] addr;
		logic [7:0]  data;
	} request_t;

	typedef struct {
		logic [15:0] ip;
		logic        zf;
		logic        sf;
		logic [15:0] rdata;
		logic        err;
	} outcome_t;

	class eu_scoreboard;
		logic [15:0] regs[8];
		logic [15:0] ip;
		logic        zf;
		logic        sf;
		logic [7:0]  mem[bit [15:0]];
		outcome_t    outcomes_due[$];
		int          errors;

		function new();
			foreach (regs[i]) regs[i] = '0;
			ip = '0;
			zf = 1'b0;
			sf = 1'b0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		function logic [15:0] reg_rd(logic w, logic [2:0] r);
			if (w)
				return regs[r];
			return r[2] ? {8'h00, regs[{1'b0, r[1:0]}][15:8]}
				: {8'h00, regs[{1'b0, r[1:0]}][7:0]};
		endfunction

		function void reg_wr(logic w, logic [2:0] r, logic [15:0] v);
			if (w)
				regs[r] = v;
			else if (r[2])
				regs[{1'b0, r[1:0]}][15:8] = v[7:0];
			else
				regs[{1'b0, r[1:0]}][7:0] = v[7:0];
		endfunction

		function logic [15:0] eff_addr(logic [1:0] mode, logic [2:0] rm, logic [15:0] disp);
			logic [15:0] base;
			case (rm)
				3'd0: base = regs[x86eu_pkg::R_BX] + regs[x86eu_pkg::R_SI];
				3'd1: base = regs[x86eu_pkg::R_BX] + regs[x86eu_pkg::R_DI];
				3'd2: base = regs[x86eu_pkg::R_BP] + regs[x86eu_pkg::R_SI];
				3'd3: base = regs[x86eu_pkg::R_BP] + regs[x86eu_pkg::R_DI];
				3'd4: base = regs[x86eu_pkg::R_SI];
				3'd5: base = regs[x86eu_pkg::R_DI];
				x86eu_pkg::RM_BP: base = (mode == 2'd0) ? 16'h0000 : regs[x86eu_pkg::R_BP];
				default: base = regs[x86eu_pkg::R_BX];
			endcase
			return base + disp;
		endfunction

		function logic [15:0] mem_rd(logic w, logic [15:0] a);
			logic [15:0] v;
			logic [15:0] a1;
			a1 = a + 16'd1;
			v = {8'h00, mem.exists(a) ? mem[a] : 8'h00};
			if (w)
				v[15:8] = mem.exists(a1) ? mem[a1] : 8'h00;
			return v;
		endfunction

		function void mem_wr(logic w, logic [15:0] a, logic [15:0] v);
			mem[a] = v[7:0];
			if (w)
				mem[a + 16'd1] = v[15:8];
		endfunction

		// is a memory read request or an exec request that reads memory (error forms read nothing)
		function bit reads_memory(request_t c);
			if (c.rq == x86eu_pkg::REQ_RDMEM)
				return 1'b1;
			return c.rq == x86eu_pkg::REQ_EXEC && c.kind <= x86eu_pkg::OP_JNE
				&& c.mode != x86eu_pkg::MOD_REG && c.kind != x86eu_pkg::OP_CMP_I;
		endfunction

		function void note(request_t c);
			outcome_t    o;
			logic [15:0] mask, ea, rmval, dst, src, res;
			bit          immform, to_reg;
			o.rdata = '0;
			o.err = 1'b0;
			mask = c.w ? 16'hFFFF : 16'h00FF;
			case (c.rq)
				x86eu_pkg::REQ_WRMEM: mem[c.addr] = c.data;
				x86eu_pkg::REQ_RDMEM: o.rdata = mem_rd(1'b1, c.addr);
				x86eu_pkg::REQ_RDREG: o.rdata = regs[c.rg];
				default: begin
					if (c.kind > x86eu_pkg::OP_JNE ||
						(c.kind == x86eu_pkg::OP_CMP_I && c.mode != x86eu_pkg::MOD_REG)) begin
						o.err = 1'b1;
					end else begin
						ea = eff_addr(c.mode, c.rm, c.disp);
						rmval = (c.mode == x86eu_pkg::MOD_REG) ? reg_rd(c.w, c.rm)
							: mem_rd(c.w, ea);
						ip = ip + {13'd0, c.len};
						case (c.kind)
							x86eu_pkg::OP_MOV_IR: reg_wr(c.w, c.rg, c.imm & mask);
							x86eu_pkg::OP_MOV_RM: begin
								if (c.d)
									reg_wr(c.w, c.rg, rmval);
								else if (c.mode == x86eu_pkg::MOD_REG)
									reg_wr(c.w, c.rm, reg_rd(c.w, c.rg));
								else
									mem_wr(c.w, ea, reg_rd(c.w, c.rg));
							end
							x86eu_pkg::OP_MOV_IM: begin
								if (c.mode == x86eu_pkg::MOD_REG)
									reg_wr(c.w, c.rm, c.imm & mask);
								else
									mem_wr(c.w, ea, c.imm & mask);
							end
							x86eu_pkg::OP_JNE: begin
								if (!zf)
									ip = ip + c.imm;
							end
							default: begin
								immform = c.kind inside {x86eu_pkg::OP_ADD_I,
									x86eu_pkg::OP_SUB_I, x86eu_pkg::OP_CMP_I};
								to_reg = !immform && c.d;
								dst = to_reg ? reg_rd(c.w, c.rg) : rmval;
								src = immform ? (c.imm & mask)
									: (to_reg ? rmval : reg_rd(c.w, c.rg));
								res = (c.kind <= x86eu_pkg::OP_ADD_I) ? dst + src : dst - src;
								res = res & mask;
								if (c.kind <= x86eu_pkg::OP_SUB_I) begin
									if (to_reg)
										reg_wr(c.w, c.rg, res);
									else if (c.mode == x86eu_pkg::MOD_REG)
										reg_wr(c.w, c.rm, res);
									else
										mem_wr(c.w, ea, res);
								end
								zf = (res == 16'h0000);
								sf = c.w ? res[15] : res[7];
							end
						endcase
					end
				end
			endcase
			o.ip = ip;
			o.zf = zf;
			o.sf = sf;
			outcomes_due.push_back(o);
		endfunction

		task check(outcome_t got);
			outcome_t exp;
			if (outcomes_due.size() == 0) begin
				report("result strobe with no request pending");
				return;
			end
			exp = outcomes_due.pop_front();
			if (got.ip !== exp.ip)
				report($sformatf("next_ip %h, expected %h", got.ip, exp.ip));
			if (got.zf !== exp.zf)
				report($sformatf("zero_flag %b, expected %b", got.zf, exp.zf));
			if (got.sf !== exp.sf)
				report($sformatf("sign_flag %b, expected %b", got.sf, exp.sf));
			if (got.rdata !== exp.rdata)
				report($sformatf("read_data %h, expected %h", got.rdata, exp.rdata));
			if (got.err !== exp.err)
				report($sformatf("error %b, expected %b", got.err, exp.err));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = '0;
	logic [3:0]  op_kind = '0;
	logic        width_bit = 1'b0;
	logic        direction_bit = 1'b0;
	logic [1:0]  mode_field = '0;
	logic [2:0]  reg_field = '0;
	logic [2:0]  rm_field = '0;
	logic [15:0] displacement = '0;
	logic [15:0] immediate = '0;
	logic [2:0]  instr_length = '0;
	logic [15:0] access_address = '0;
	logic [7:0]  access_data = '0;
	logic        done;
	logic [15:0] next_ip;
	logic        zero_flag;
	logic        sign_flag;
	logic [15:0] read_data;
	logic        error;

	eu_scoreboard sb = new();
	int           cycles = 0;
	int           idle_pct = 24;

	x86_16bit_execute_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .op_kind(op_kind), .width_bit(width_bit),
		.direction_bit(direction_bit), .mode_field(mode_field),
		.reg_field(reg_field), .rm_field(rm_field), .displacement(displacement),
		.immediate(immediate), .instr_length(instr_length),
		.access_address(access_address), .access_data(access_data),
		.done(done), .next_ip(next_ip), .zero_flag(zero_flag),
		.sign_flag(sign_flag), .read_data(read_data), .error(error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		outcome_t got;
		if (arst_n && done) begin
			got.ip = next_ip;
			got.zf = zero_flag;
			got.sf = sign_flag;
			got.rdata = read_data;
			got.err = error;
			sb.check(got);
		end
	end

	function automatic request_t exec_req(logic [3:0] kind, logic w, logic d, logic [1:0] mode,
			logic [2:0] rg, logic [2:0] rm, logic [15:0] disp, logic [15:0] imm, logic [2:0] len);
		request_t c;
		c = '{rq: x86eu_pkg::REQ_EXEC, kind: kind, w: w, d: d, mode: mode, rg: rg, rm: rm,
			disp: disp, imm: imm, len: len, addr: 16'($urandom), data: 8'($urandom)};
		return c;
	endfunction

	function automatic request_t side_req(x86eu_pkg::req_t rq, logic [2:0] rg,
			logic [15:0] addr, logic [7:0] data);
		request_t c;
		c = '{rq: rq, kind: 4'($urandom), w: 1'($urandom), d: 1'($urandom),
			mode: 2'($urandom), rg: rg, rm: 3'($urandom), disp: 16'($urandom),
			imm: 16'($urandom), len: 3'($urandom), addr: addr, data: data};
		return c;
	endfunction

	// hand one request over and hold it until the block takes it
	task automatic issue(request_t c);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_type <= c.rq;
		op_kind <= c.kind;
		width_bit <= c.w;
		direction_bit <= c.d;
		mode_field <= c.mode;
		reg_field <= c.rg;
		rm_field <= c.rm;
		displacement <= c.disp;
		immediate <= c.imm;
		instr_length <= c.len;
		access_address <= c.addr;
		access_data <= c.data;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sb.note(c);
	endtask

	// fill any unwritten byte that the request would read, then send it
	task automatic send(request_t c);
		logic [15:0] a;
		bit          two;
		if (sb.reads_memory(c)) begin
			two = (c.rq == x86eu_pkg::REQ_RDMEM) || c.w;
			a = (c.rq == x86eu_pkg::REQ_RDMEM) ? c.addr : sb.eff_addr(c.mode, c.rm, c.disp);
			if (!sb.mem.exists(a))
				issue(side_req(x86eu_pkg::REQ_WRMEM, 3'($urandom), a, 8'($urandom)));
			if (two && !sb.mem.exists(a + 16'd1))
				issue(side_req(x86eu_pkg::REQ_WRMEM, 3'($urandom), a + 16'd1,
					8'($urandom)));
		end
		issue(c);
	endtask

	function automatic request_t random_req();
		request_t c;
		int       p;
		p = $urandom_range(0, 99);
		c = exec_req(4'($urandom_range(0, 9)), 1'($urandom), 1'($urandom), 2'($urandom),
			3'($urandom), 3'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
		if ($urandom_range(0, 1))
			c.mode = x86eu_pkg::MOD_REG;
		if ($urandom_range(0, 1))
			c.disp = 16'($urandom_range(0, 31));
		if ($urandom_range(0, 29) == 0)
			c.kind = 4'($urandom_range(10, 15));
		// aim some compares and subtracts at a zero result
		if (c.kind inside {x86eu_pkg::OP_CMP_I, x86eu_pkg::OP_SUB_I} &&
			$urandom_range(0, 3) == 0)
			c.imm = sb.reg_rd(c.w, c.rm);
		if (p < 8)
			c = side_req(x86eu_pkg::REQ_WRMEM, 3'($urandom), 16'($urandom), 8'($urandom));
		else if (p < 16)
			c = side_req(x86eu_pkg::REQ_RDMEM, 3'($urandom), 16'($urandom), 8'($urandom));
		else if (p < 24)
			c = side_req(x86eu_pkg::REQ_RDREG, 3'($urandom), 16'($urandom), 8'($urandom));
		return c;
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 0;
		send(side_req(x86eu_pkg::REQ_WRMEM, x86eu_pkg::R_BX, 16'h0010, 8'h34));
		send(side_req(x86eu_pkg::REQ_WRMEM, x86eu_pkg::R_BX, 16'h0011, 8'h12));
		send(exec_req(x86eu_pkg::OP_MOV_IR, 1'b1, 1'b0, x86eu_pkg::MOD_REG,
			x86eu_pkg::R_BX, 3'd0, 16'h0000, 16'h0010, 3'd3));
		send(exec_req(x86eu_pkg::OP_MOV_RM, 1'b1, 1'b1, 2'd0, 3'd0, 3'd7,
			16'h0000, 16'h0000, 3'd2));
		send(exec_req(x86eu_pkg::OP_MOV_IR, 1'b0, 1'b0, x86eu_pkg::MOD_REG, 3'd4, 3'd0,
			16'h0000, 16'hFF80, 3'd2));
		send(exec_req(x86eu_pkg::OP_MOV_RM, 1'b0, 1'b0, x86eu_pkg::MOD_REG, 3'd4, 3'd1,
			16'h0000, 16'h0000, 3'd2));
		send(exec_req(x86eu_pkg::OP_ADD_I, 1'b1, 1'b0, x86eu_pkg::MOD_REG, 3'd0, 3'd0,
			16'h0000, 16'hFFFF, 3'd0));
		send(exec_req(x86eu_pkg::OP_SUB, 1'b0, 1'b1, x86eu_pkg::MOD_REG, 3'd1, 3'd1,
			16'h0000, 16'h0000, 3'd2));
		send(exec_req(x86eu_pkg::OP_JNE, 1'b1, 1'b0, x86eu_pkg::MOD_REG, 3'd0, 3'd0,
			16'h0000, 16'h0100, 3'd2));
		send(exec_req(x86eu_pkg::OP_CMP_I, 1'b1, 1'b0, x86eu_pkg::MOD_REG, 3'd0, 3'd0,
			16'h0000, 16'h0001, 3'd7));
		send(exec_req(x86eu_pkg::OP_JNE, 1'b1, 1'b0, x86eu_pkg::MOD_REG, 3'd0, 3'd0,
			16'h0000, 16'hFFF0, 3'd2));
		send(exec_req(x86eu_pkg::OP_MOV_IM, 1'b1, 1'b0, 2'd2, 3'd0, x86eu_pkg::RM_BP,
			16'hFFFF, 16'hBEEF, 3'd6));
		send(exec_req(x86eu_pkg::OP_ADD, 1'b1, 1'b0, 2'd1, 3'd0, x86eu_pkg::RM_BP,
			16'hFFFF, 16'h0000, 3'd3));
		send(exec_req(x86eu_pkg::OP_CMP, 1'b0, 1'b1, 2'd0, 3'd6, x86eu_pkg::RM_BP,
			16'h0010, 16'h0000, 3'd4));
		send(exec_req(x86eu_pkg::OP_CMP_I, 1'b1, 1'b0, 2'd0, 3'd0, 3'd7,
			16'h0000, 16'h1234, 3'd4));
		send(exec_req(4'd15, 1'b1, 1'b1, x86eu_pkg::MOD_REG, 3'd7, 3'd7,
			16'hFFFF, 16'hFFFF, 3'd7));
		send(exec_req(x86eu_pkg::OP_SUB_I, 1'b0, 1'b0, x86eu_pkg::MOD_REG, 3'd0, 3'd7,
			16'h0000, 16'h0080, 3'd3));
		send(exec_req(x86eu_pkg::OP_SUB, 1'b1, 1'b0, 2'd0, 3'd1, 3'd4,
			16'h8000, 16'h0000, 3'd2));
		send(exec_req(x86eu_pkg::OP_MOV_RM, 1'b0, 1'b0, 2'd1, 3'd7, 3'd0,
			16'h0001, 16'h0000, 3'd3));
		send(side_req(x86eu_pkg::REQ_RDMEM, 3'd0, 16'hFFFF, 8'hFF));
		send(side_req(x86eu_pkg::REQ_RDREG, 3'd0, 16'h0000, 8'h00));
		send(side_req(x86eu_pkg::REQ_RDREG, 3'd1, 16'h0000, 8'h00));
		send(side_req(x86eu_pkg::REQ_RDREG, 3'd7, 16'h0000, 8'h00));

		for (int i = 0; i < RANDOM_REQS; i++) begin
			idle_pct = (i >= 400 && i < 700) ? 0 : 24;
			if (i == 800) begin
				start <= 1'b0;
				while (sb.outcomes_due.size() != 0)
					@(posedge clk);
			end
			send(random_req());
		end
		start <= 1'b0;

		while (sb.outcomes_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

FILE: files.f
+incdir+hdl
hdl/x86eu_pkg.sv
hdl/x86eu_alu.sv
hdl/x86eu_mem.sv
hdl/x86_16bit_execute_unit.sv
hdl/x86eu_checker.sv
dv/tb.sv
